// File: rtl/hfd_pkg.sv
// Package for the hysteretic friction damper step block.
// Holds sequencer states, register indexes and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package hfd_pkg;

   localparam int unsigned DATA_W  = 32;  // displacement, force, state width
   localparam int unsigned REG_W   = 31;  // configuration register width
   localparam int unsigned IDX_W   = 3;   // configuration index width
   localparam int unsigned OPND_W  = 33;  // shared multiplier operand width
   localparam int unsigned PROD_W  = 2 * OPND_W;
   localparam int unsigned FRAC_W  = 16;  // Q16.16 fraction bits
   localparam int unsigned HQ_W    = 17;  // hysteretic factor, 0 .. 1.0

   localparam logic [HQ_W-1:0] HQ_ONE = 17'h10000;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_YIELD_LEVEL   = 3'd0;
   localparam logic [IDX_W-1:0] REG_PLASTIC_LEVEL = 3'd1;
   localparam logic [IDX_W-1:0] REG_BAND_INVERSE  = 3'd2;
   localparam logic [IDX_W-1:0] REG_FORCE_GAIN    = 3'd3;
   localparam logic [IDX_W-1:0] REG_TIME_STEP     = 3'd4;

   // reset values
   localparam logic [REG_W-1:0] RST_YIELD_LEVEL   = 31'd0;
   localparam logic [REG_W-1:0] RST_PLASTIC_LEVEL = 31'd65536;
   localparam logic [REG_W-1:0] RST_BAND_INVERSE  = 31'd65536;
   localparam logic [REG_W-1:0] RST_FORCE_GAIN    = 31'd0;

   typedef enum logic [2:0] {
      ST_IDLE,   // waiting for a transaction
      ST_HQ,     // multiply (plastic - |q|) by band inverse
      ST_INC,    // multiply hysteretic factor by displacement change
      ST_QUPD,   // update and clamp q
      ST_FORCE,  // multiply force gain by q
      ST_SAT     // saturate force into the output register
   } state_type;

endpackage

// File: rtl/hfd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hfd_pkg for operand widths.
`timescale 1ns / 1ps

module hfd_mul (
   input  logic                                   clock,
   input  logic signed [hfd_pkg::OPND_W-1:0]      mul_a,
   input  logic signed [hfd_pkg::OPND_W-1:0]      mul_b,
   output logic signed [hfd_pkg::PROD_W-1:0]      product
);

   logic signed [hfd_pkg::PROD_W-1:0] product_ff;
   logic signed [hfd_pkg::PROD_W-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: rtl/hysteretic_friction_damper_step.sv
// Top level of the hysteretic friction damper step: sequencer, state and datapath.
// Depends on hfd_pkg and the shared multiplier hfd_mul.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_displacement (s32 Q16.16)
//   rsp      out        rsp_valid/rsp_stall  rsp_damper_force (s32 Q16.16)
//   csr      in         csr_wr_en            csr_index, csr_wdata (31 bits)
//
// Each transaction runs through the steps HQ, INC, QUPD, FORCE and SAT into the result
// register; a new one cannot be accepted before the previous one has left the last step.
// Three products pass one by one through the single shared 33x33 multiplier.
// A new transaction is accepted only while the sequencer is idle.
// If the previous result is still stalled, the sequencer holds in its last step.
// Reset is synchronous: clears state and the output valid, and loads the configuration reset values.
`timescale 1ns / 1ps

module hysteretic_friction_damper_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [hfd_pkg::DATA_W-1:0]   req_displacement,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [hfd_pkg::DATA_W-1:0]   rsp_damper_force,
   input  logic                                csr_wr_en,
   input  logic        [hfd_pkg::IDX_W-1:0]    csr_index,
   input  logic        [hfd_pkg::REG_W-1:0]    csr_wdata
);

   localparam int unsigned DW  = hfd_pkg::DATA_W;
   localparam int unsigned OW  = hfd_pkg::OPND_W;
   localparam int unsigned PW  = hfd_pkg::PROD_W;
   localparam int unsigned FW  = hfd_pkg::FRAC_W;
   localparam int unsigned RW  = hfd_pkg::REG_W;
   localparam int unsigned HW  = hfd_pkg::HQ_W;
   localparam int unsigned SHW = PW - FW;  // width of a product after the Q16 shift

   hfd_pkg::state_type state_ff, state_in;

   // configuration
   logic [RW-1:0] yield_ff, plastic_ff, band_ff, gain_ff;

   // architectural state
   logic signed [DW-1:0] prev_ff, prev_in;
   logic signed [DW-1:0] q_ff, q_in;

   // per-transaction work registers
   logic signed [DW-1:0] u_ff, u_in;
   logic signed [OW-1:0] d_ff, d_in;
   logic                 one_ff, one_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_force_ff, rsp_force_in;

   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] product;
   logic signed [SHW-1:0] prod_shift;

   logic                 req_take;
   logic                 out_free;

   logic signed [OW-1:0] q_ext;
   logic signed [OW-1:0] aq;
   logic signed [OW:0]   band_diff;
   logic                 same_sign;
   logic [HW-1:0]        hq;
   logic signed [SHW:0]  q_sum;
   logic signed [SHW:0]  plim_pos, plim_neg;
   logic signed [SHW:0]  f_neg;

   hfd_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign req_stall = (state_ff != hfd_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_damper_force = rsp_force_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         yield_ff   <= hfd_pkg::RST_YIELD_LEVEL;
         plastic_ff <= hfd_pkg::RST_PLASTIC_LEVEL;
         band_ff    <= hfd_pkg::RST_BAND_INVERSE;
         gain_ff    <= hfd_pkg::RST_FORCE_GAIN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hfd_pkg::REG_YIELD_LEVEL:   yield_ff   <= csr_wdata;
            hfd_pkg::REG_PLASTIC_LEVEL: plastic_ff <= csr_wdata;
            hfd_pkg::REG_BAND_INVERSE:  band_ff    <= csr_wdata;
            hfd_pkg::REG_FORCE_GAIN:    gain_ff    <= csr_wdata;
            // time step only sets the velocity scale; the sign of d suffices
            hfd_pkg::REG_TIME_STEP: ;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hfd_pkg::ST_IDLE:  if (req_take) state_in = hfd_pkg::ST_HQ;
         hfd_pkg::ST_HQ:    state_in = hfd_pkg::ST_INC;
         hfd_pkg::ST_INC:   state_in = hfd_pkg::ST_QUPD;
         hfd_pkg::ST_QUPD:  state_in = hfd_pkg::ST_FORCE;
         hfd_pkg::ST_FORCE: state_in = hfd_pkg::ST_SAT;
         hfd_pkg::ST_SAT:   if (out_free) state_in = hfd_pkg::ST_IDLE;
         default:           state_in = hfd_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath terms
   assign q_ext      = OW'(q_ff);
   assign aq         = q_ff[DW-1] ? -q_ext : q_ext;
   assign band_diff  = $signed({2'b00, plastic_ff}) - (OW+1)'(aq);
   assign same_sign  = (q_ff > 0 && d_ff > 0) || (q_ff < 0 && d_ff < 0);
   assign prod_shift = product[PW-1:FW];  // floor(p / 2^16)
   assign plim_pos   = $signed({{(SHW+1-RW){1'b0}}, plastic_ff});
   assign plim_neg   = -plim_pos;

   // saturate the hysteretic factor to [0, 1.0]
   always_comb begin
      if (one_ff)
         hq = hfd_pkg::HQ_ONE;
      else if (prod_shift < 0)
         hq = '0;
      else if (prod_shift > $signed({{(SHW-HW){1'b0}}, hfd_pkg::HQ_ONE}))
         hq = hfd_pkg::HQ_ONE;
      else
         hq = prod_shift[HW-1:0];
   end

   assign q_sum = (SHW+1)'(q_ff) + (SHW+1)'(prod_shift);
   assign f_neg = -(SHW+1)'(prod_shift);

   // ---------------------------------------------------------------- outputs / regs
   always_comb begin
      mul_a        = '0;
      mul_b        = '0;
      u_in         = u_ff;
      d_in         = d_ff;
      one_in       = one_ff;
      prev_in      = prev_ff;
      q_in         = q_ff;
      rsp_force_in = rsp_force_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         hfd_pkg::ST_IDLE: begin
            if (req_take) begin
               u_in = req_displacement;
               d_in = OW'(req_displacement) - OW'(prev_ff);
            end
         end
         hfd_pkg::ST_HQ: begin
            mul_a  = band_diff[OW-1:0];
            mul_b  = $signed({{(OW-RW){1'b0}}, band_ff});
            one_in = (aq <= $signed({{(OW-RW){1'b0}}, yield_ff})) || !same_sign;
         end
         hfd_pkg::ST_INC: begin
            mul_a = $signed({{(OW-HW){1'b0}}, hq});
            mul_b = d_ff;
         end
         hfd_pkg::ST_QUPD: begin
            prev_in = u_ff;
            if (q_sum > plim_pos)
               q_in = plim_pos[DW-1:0];
            else if (q_sum < plim_neg)
               q_in = plim_neg[DW-1:0];
            else
               q_in = q_sum[DW-1:0];
         end
         hfd_pkg::ST_FORCE: begin
            mul_a = $signed({{(OW-RW){1'b0}}, gain_ff});
            mul_b = q_ext;
         end
         hfd_pkg::ST_SAT: begin
            // keep the force product alive while the previous result waits
            mul_a = $signed({{(OW-RW){1'b0}}, gain_ff});
            mul_b = q_ext;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (f_neg > (SHW+1)'(32'sh7fffffff))
                  rsp_force_in = 32'sh7fffffff;
               else if (f_neg < -(SHW+1)'(33'sh080000000))
                  rsp_force_in = 32'sh80000000;
               else
                  rsp_force_in = f_neg[DW-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hfd_pkg::ST_IDLE;
         prev_ff      <= '0;
         q_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         q_ff         <= q_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff         <= u_in;
      d_ff         <= d_in;
      one_ff       <= one_in;
      rsp_force_ff <= rsp_force_in;
   end

   // ---------------------------------------------------------------- assertions
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == hfd_pkg::ST_HQ)
      else $error("accepted transaction did not start the sequence");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hfd_pkg::ST_SAT && out_free) |=> rsp_valid_ff)
      else $error("result not presented after the last step");

   a_prev_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == hfd_pkg::ST_QUPD |=> prev_ff == $past(u_ff))
      else $error("previous displacement not updated");

   a_hq_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == hfd_pkg::ST_INC |-> hq <= hfd_pkg::HQ_ONE)
      else $error("hysteretic factor above one");

endmodule

// File: verif/hysteretic_friction_damper_step_tb.sv
// Self-checking testbench for hysteretic_friction_damper_step: directed and random
// displacement streams under changing damper settings, with random idling on both sides.
// Depends on hfd_pkg and the block's RTL.
`timescale 1ns / 1ps

module hysteretic_friction_damper_step_tb;

   localparam longint FORCE_MAX = 64'sd2147483647;
   localparam longint FORCE_MIN = -64'sd2147483648;
   localparam logic [hfd_pkg::REG_W-1:0] REG_MAX = '1;
   localparam int PHASE_ITEMS = 112;
   localparam int RANDOM_PHASES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [hfd_pkg::DATA_W-1:0] req_displacement = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [hfd_pkg::DATA_W-1:0] rsp_damper_force;
   logic csr_wr_en = 1'b0;
   logic [hfd_pkg::IDX_W-1:0] csr_index = '0;
   logic [hfd_pkg::REG_W-1:0] csr_wdata = '0;

   hysteretic_friction_damper_step dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_displacement (req_displacement),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_damper_force (rsp_damper_force),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // damper settings and state as tracked by the testbench
   logic [hfd_pkg::REG_W-1:0] yield_lvl = hfd_pkg::RST_YIELD_LEVEL;
   logic [hfd_pkg::REG_W-1:0] plastic_lvl = hfd_pkg::RST_PLASTIC_LEVEL;
   logic [hfd_pkg::REG_W-1:0] band_inv = hfd_pkg::RST_BAND_INVERSE;
   logic [hfd_pkg::REG_W-1:0] force_gn = hfd_pkg::RST_FORCE_GAIN;
   logic [hfd_pkg::REG_W-1:0] sample_interval = 31'd65536;
   logic signed [hfd_pkg::DATA_W-1:0] prev_disp = '0;
   logic signed [hfd_pkg::DATA_W-1:0] hyst_q = '0;

   logic signed [hfd_pkg::DATA_W-1:0] pending_disp[$];
   logic signed [hfd_pkg::DATA_W-1:0] expected_force[$];

   logic req_fire = 1'b0;
   logic quiet = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int error_count = 0;

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // one damper step: advances the tracked state, returns the force
   function automatic logic signed [hfd_pkg::DATA_W-1:0] step_damper(
      input logic signed [hfd_pkg::DATA_W-1:0] disp);
      longint q, d, aq, plim, hq, f;
      q = longint'(hyst_q);
      d = longint'(disp) - longint'(prev_disp);
      aq = (q < 0) ? -q : q;
      plim = longint'(plastic_lvl);
      if (aq <= longint'(yield_lvl) || !((q > 0 && d > 0) || (q < 0 && d < 0))) begin
         hq = longint'(hfd_pkg::HQ_ONE);
      end else begin
         hq = ((plim - aq) * longint'(band_inv)) >>> hfd_pkg::FRAC_W;
         if (hq < 0) hq = 0;
         if (hq > longint'(hfd_pkg::HQ_ONE)) hq = longint'(hfd_pkg::HQ_ONE);
      end
      q = q + ((hq * d) >>> hfd_pkg::FRAC_W);
      if (q > plim) q = plim;
      else if (q < -plim) q = -plim;
      hyst_q = q[hfd_pkg::DATA_W-1:0];
      f = -((longint'(force_gn) * q) >>> hfd_pkg::FRAC_W);
      if (f > FORCE_MAX) f = FORCE_MAX;
      else if (f < FORCE_MIN) f = FORCE_MIN;
      prev_disp = disp;
      return f[hfd_pkg::DATA_W-1:0];
   endfunction

   // scoreboard: register writes, result check, then prediction of new transactions
   always @(posedge clock) begin
      if (reset) begin
         yield_lvl = hfd_pkg::RST_YIELD_LEVEL;
         plastic_lvl = hfd_pkg::RST_PLASTIC_LEVEL;
         band_inv = hfd_pkg::RST_BAND_INVERSE;
         force_gn = hfd_pkg::RST_FORCE_GAIN;
         sample_interval = 31'd65536;
         prev_disp = '0;
         hyst_q = '0;
         req_fire <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               hfd_pkg::REG_YIELD_LEVEL:   yield_lvl = csr_wdata;
               hfd_pkg::REG_PLASTIC_LEVEL: plastic_lvl = csr_wdata;
               hfd_pkg::REG_BAND_INVERSE:  band_inv = csr_wdata;
               hfd_pkg::REG_FORCE_GAIN:    force_gn = csr_wdata;
               hfd_pkg::REG_TIME_STEP:     sample_interval = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_force.size() == 0)
               flag_error($sformatf("unexpected result force=%0d", rsp_damper_force));
            else if (rsp_damper_force !== expected_force[0])
               flag_error($sformatf("damper_force got %0d expected %0d",
                                    rsp_damper_force, expected_force[0]));
            if (expected_force.size() != 0) void'(expected_force.pop_front());
         end
         if (req_valid && !req_stall)
            expected_force.push_back(step_damper(req_displacement));
         req_fire <= req_valid && !req_stall;
      end
   end

   // sender: holds a stalled transaction, otherwise moves on with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_disp.size() != 0) begin
            req_valid <= 1'b1;
            req_displacement <= pending_disp.pop_front();
            if (!quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input logic [hfd_pkg::IDX_W-1:0] idx,
                            input logic [hfd_pkg::REG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all(input logic [hfd_pkg::REG_W-1:0] ylev,
                            input logic [hfd_pkg::REG_W-1:0] plim,
                            input logic [hfd_pkg::REG_W-1:0] binv,
                            input logic [hfd_pkg::REG_W-1:0] gain,
                            input logic [hfd_pkg::REG_W-1:0] tstep);
      write_reg(hfd_pkg::REG_YIELD_LEVEL, ylev);
      write_reg(hfd_pkg::REG_PLASTIC_LEVEL, plim);
      write_reg(hfd_pkg::REG_BAND_INVERSE, binv);
      write_reg(hfd_pkg::REG_FORCE_GAIN, gain);
      write_reg(hfd_pkg::REG_TIME_STEP, tstep);
   endtask

   // sender paused: every expected result is in and the block has settled
   task automatic wait_drained();
      while (pending_disp.size() != 0 || req_valid || expected_force.size() != 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [hfd_pkg::REG_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return REG_MAX;
         2: return hfd_pkg::REG_W'($urandom);
         default: return hfd_pkg::REG_W'($urandom_range(0, 32'h40000));
      endcase
   endfunction

   task automatic config_random(output longint span);
      logic [hfd_pkg::REG_W-1:0] plim, ylev, binv;
      longint recip;
      if ($urandom_range(0, 2) == 0) begin
         plim = pick_level();
         ylev = pick_level();
         binv = pick_level();
      end else begin
         // consistent levels with the matching band reciprocal
         plim = hfd_pkg::REG_W'($urandom_range(32'h100, 32'h80000));
         ylev = hfd_pkg::REG_W'($urandom_range(0, plim - 1));
         recip = (64'sd1 <<< 32) / longint'(plim - ylev);
         binv = (recip > longint'(REG_MAX)) ? REG_MAX : recip[hfd_pkg::REG_W-1:0];
      end
      write_all(ylev, plim, binv, pick_level(),
                hfd_pkg::REG_W'($urandom_range(1, 32'h7FFFFFFF)));
      span = longint'(plim) / 3 + 16;
   endtask

   // oscillating displacement walk, with some full-range and repeated samples
   task automatic queue_walk(input int count, input longint span);
      longint pos, dir;
      logic signed [hfd_pkg::DATA_W-1:0] value;
      pos = 0;
      dir = 1;
      value = '0;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: value = $urandom;
            1: ;  // zero velocity
            default: begin
               if ($urandom_range(0, 7) == 0) dir = -dir;
               pos = pos + dir * longint'($urandom_range(0, 32'(span)));
               if (pos > FORCE_MAX || pos < FORCE_MIN) begin
                  pos = (pos > 0) ? FORCE_MAX : FORCE_MIN;
                  dir = -dir;
               end
               value = pos[hfd_pkg::DATA_W-1:0];
            end
         endcase
         pending_disp.push_back(value);
      end
   endtask

   initial begin
      longint span;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero gain, only q moves
      pending_disp.push_back(32'sh0002_0000);
      pending_disp.push_back(32'sh0000_8000);
      pending_disp.push_back(-32'sh0003_0000);
      wait_drained();

      // yield 0.25, plastic 1.0; indexes past the last register are ignored
      write_all(31'h4000, 31'h10000, 31'h15555, 31'h30000, 31'h10000);
      for (int i = int'(hfd_pkg::REG_TIME_STEP) + 1; i < (1 << hfd_pkg::IDX_W); i++)
         write_reg(hfd_pkg::IDX_W'(i), REG_MAX);
      pending_disp.push_back(32'sh0000_2000);
      pending_disp.push_back(32'sh0000_6000);
      pending_disp.push_back(32'sh0000_C000);
      pending_disp.push_back(32'sh0001_8000);
      pending_disp.push_back(32'sh0001_8000);
      pending_disp.push_back(32'sh0001_0000);
      pending_disp.push_back(-32'sh0001_0000);
      pending_disp.push_back(-32'sh0004_0000);
      pending_disp.push_back(32'sh7FFF_FFFF);
      pending_disp.push_back(32'sh8000_0000);
      pending_disp.push_back(32'sh0000_0001);
      pending_disp.push_back(-32'sh0000_0001);
      wait_drained();

      // plastic lowered under |q| (factor floors at zero), huge band reciprocal,
      // zero time step
      write_all(31'h0, 31'h2000, REG_MAX, 31'h10000, 31'h0);
      pending_disp.push_back(-32'sh0002_0000);
      pending_disp.push_back(32'sh0001_0000);
      pending_disp.push_back(32'sh0003_0000);
      wait_drained();

      // maximum levels and gain: force saturates
      write_all(31'h0, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
      pending_disp.push_back(32'sh7FFF_FFFF);
      pending_disp.push_back(32'sh8000_0000);
      pending_disp.push_back(32'sh4000_0000);
      wait_drained();

      // levels and gain all zero: q pinned at zero
      write_all(31'h0, 31'h0, 31'h0, 31'h0, 31'h1);
      pending_disp.push_back(32'sh0000_1000);
      pending_disp.push_back(-32'sh0000_1000);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
         config_random(span);
         queue_walk(PHASE_ITEMS, span);
      end
      wait_drained();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: hysteretic_friction_damper_step.f
rtl/hfd_pkg.sv
rtl/hfd_mul.sv
rtl/hysteretic_friction_damper_step.sv
verif/hysteretic_friction_damper_step_tb.sv
